[hdl/wmsm_pkg.sv]
// ============================================================================
// wmsm_pkg: shared types and constants of the weighted multi-stream mixer
// Field widths, fixed-point layout, register map and sample format codes.
// ============================================================================
package wmsm_pkg;

    // Extra streams that have registers and sample inputs.
    localparam int NUM_EXTRA = 3;
    localparam int LANES     = NUM_EXTRA + 1;
    localparam int CNT_W     = 2;

    localparam int SAMPLE_W  = 24;
    localparam int GAIN_W    = 24;
    localparam int LEN_W     = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int Q_W       = SUM_W - FRAC_BITS;

    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic [8:0] EIGHT_BIT_OFFSET = 9'd128;

    // Sample format codes; code 3 behaves as 24-bit.
    localparam logic [1:0] FMT_8BIT  = 2'd0;
    localparam logic [1:0] FMT_16BIT = 2'd1;
    localparam logic [1:0] FMT_24BIT = 2'd2;

    // Register indexes, byte address = 4 * index.
    localparam logic [2:0] REG_SAMPLE_FORMAT = 3'd0;
    localparam logic [2:0] REG_MAIN_GAIN     = 3'd1;
    localparam logic [2:0] REG_EXTRA_GAIN_A  = 3'd2;
    localparam logic [2:0] REG_EXTRA_GAIN_B  = 3'd3;
    localparam logic [2:0] REG_EXTRA_GAIN_C  = 3'd4;
    localparam logic [2:0] REG_EXTRA_LEN_A   = 3'd5;
    localparam logic [2:0] REG_EXTRA_LEN_B   = 3'd6;
    localparam logic [2:0] REG_EXTRA_LEN_C   = 3'd7;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'd65536;

    typedef struct packed {
        logic [1:0]                        sample_format;
        logic [GAIN_W-1:0]                 main_gain;
        logic [NUM_EXTRA-1:0][GAIN_W-1:0]  extra_gain;
        logic [NUM_EXTRA-1:0][LEN_W-1:0]   extra_len;
    } wmsm_cfg_t;

    // Load enables of the five pipeline stages.
    typedef struct packed {
        logic load;
        logic mult;
        logic sum;
        logic rnd;
        logic sat;
    } wmsm_pipe_en_t;

endpackage

[hdl/wmsm_if.sv]
// ============================================================================
// wmsm_if: stream channels of the weighted multi-stream mixer
// Input channel carries one channel element, output channel one mixed sample.
// ============================================================================
interface wmsm_in_if;
    logic                     valid;
    logic                     ready;
    logic [31:0]              frame_index;
    logic signed [23:0]       main_sample;
    logic signed [23:0]       extra_sample_a;
    logic signed [23:0]       extra_sample_b;
    logic signed [23:0]       extra_sample_c;

    modport source (
        output valid, frame_index, main_sample, extra_sample_a, extra_sample_b,
               extra_sample_c,
        input  ready
    );
    modport sink (
        input  valid, frame_index, main_sample, extra_sample_a, extra_sample_b,
               extra_sample_c,
        output ready
    );
endinterface

interface wmsm_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [23:0]       mixed_sample;

    modport source (
        output valid, mixed_sample,
        input  ready
    );
    modport sink (
        input  valid, mixed_sample,
        output ready
    );
endinterface

[hdl/wmsm_regs.sv]
// ============================================================================
// wmsm_regs: configuration register file
// APB-style write and read access to format, gains and stream lengths.
// ============================================================================
module wmsm_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wmsm_pkg::ADDR_W-1:0]   paddr,
    input  logic [wmsm_pkg::DATA_W-1:0]   pwdata,
    output logic [wmsm_pkg::DATA_W-1:0]   prdata,
    output wmsm_pkg::wmsm_cfg_t           cfg
);

    wmsm_pkg::wmsm_cfg_t cfg_reg;
    wmsm_pkg::wmsm_cfg_t cfg_next;
    logic                wr_en;
    logic [2:0]          reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                wmsm_pkg::REG_SAMPLE_FORMAT: cfg_next.sample_format = pwdata[1:0];
                wmsm_pkg::REG_MAIN_GAIN:     cfg_next.main_gain     = pwdata[23:0];
                wmsm_pkg::REG_EXTRA_GAIN_A:  cfg_next.extra_gain[0] = pwdata[23:0];
                wmsm_pkg::REG_EXTRA_GAIN_B:  cfg_next.extra_gain[1] = pwdata[23:0];
                wmsm_pkg::REG_EXTRA_GAIN_C:  cfg_next.extra_gain[2] = pwdata[23:0];
                wmsm_pkg::REG_EXTRA_LEN_A:   cfg_next.extra_len[0]  = pwdata;
                wmsm_pkg::REG_EXTRA_LEN_B:   cfg_next.extra_len[1]  = pwdata;
                wmsm_pkg::REG_EXTRA_LEN_C:   cfg_next.extra_len[2]  = pwdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_format <= wmsm_pkg::FMT_16BIT;
            cfg_reg.main_gain     <= wmsm_pkg::UNITY_GAIN;
            for (int i = 0; i < wmsm_pkg::NUM_EXTRA; i++)
            begin
                cfg_reg.extra_gain[i] <= wmsm_pkg::UNITY_GAIN;
                cfg_reg.extra_len[i]  <= '0;
            end
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Gains read back sign-extended to the bus width.
    always_comb
    begin
        unique case (reg_idx)
            wmsm_pkg::REG_SAMPLE_FORMAT: prdata = {30'd0, cfg_reg.sample_format};
            wmsm_pkg::REG_MAIN_GAIN:
                prdata = {{8{cfg_reg.main_gain[23]}}, cfg_reg.main_gain};
            wmsm_pkg::REG_EXTRA_GAIN_A:
                prdata = {{8{cfg_reg.extra_gain[0][23]}}, cfg_reg.extra_gain[0]};
            wmsm_pkg::REG_EXTRA_GAIN_B:
                prdata = {{8{cfg_reg.extra_gain[1][23]}}, cfg_reg.extra_gain[1]};
            wmsm_pkg::REG_EXTRA_GAIN_C:
                prdata = {{8{cfg_reg.extra_gain[2][23]}}, cfg_reg.extra_gain[2]};
            wmsm_pkg::REG_EXTRA_LEN_A:   prdata = cfg_reg.extra_len[0];
            wmsm_pkg::REG_EXTRA_LEN_B:   prdata = cfg_reg.extra_len[1];
            wmsm_pkg::REG_EXTRA_LEN_C:   prdata = cfg_reg.extra_len[2];
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[hdl/wmsm_lane.sv]
// ============================================================================
// wmsm_lane: one gain lane of the mixer
// Converts a stream sample and multiplies it by its gain, two register stages.
// ============================================================================
module wmsm_lane (
    input  logic                                clk,
    input  wmsm_pkg::wmsm_pipe_en_t             en,
    input  logic                                offset_mode,
    input  logic                                lane_on,
    input  logic [wmsm_pkg::SAMPLE_W-1:0]       raw_sample,
    input  logic signed [wmsm_pkg::GAIN_W-1:0]  gain,
    output logic signed [wmsm_pkg::PROD_W-1:0]  product
);

    logic signed [wmsm_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [wmsm_pkg::SAMPLE_W-1:0] sample_next;
    logic                                 on_reg;
    logic signed [wmsm_pkg::PROD_W-1:0]   prod_reg;
    logic signed [wmsm_pkg::PROD_W-1:0]   prod_next;
    logic [8:0]                           centered;

    // Unsigned 8-bit samples are centered around zero.
    assign centered = {1'b0, raw_sample[7:0]} - wmsm_pkg::EIGHT_BIT_OFFSET;

    always_comb
    begin
        if (offset_mode)
            sample_next = {{(wmsm_pkg::SAMPLE_W - 9){centered[8]}}, centered};
        else
            sample_next = raw_sample;
    end

    always_comb
    begin
        if (on_reg)
            prod_next = sample_reg * gain;
        else
            prod_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en.load)
        begin
            sample_reg <= sample_next;
            on_reg     <= lane_on;
        end
        if (en.mult)
            prod_reg <= prod_next;
    end

    assign product = prod_reg;

endmodule

[hdl/wmsm_merge.sv]
// ============================================================================
// wmsm_merge: merging stage of the mixer
// Sums the lane products, rounds half away from zero and saturates.
// ============================================================================
module wmsm_merge (
    input  logic                                                  clk,
    input  wmsm_pkg::wmsm_pipe_en_t                               en,
    input  logic [1:0]                                            sample_format,
    input  logic [wmsm_pkg::LANES-1:0][wmsm_pkg::PROD_W-1:0]      products,
    output logic signed [wmsm_pkg::SAMPLE_W-1:0]                  mixed
);

    localparam int SUM_W = wmsm_pkg::SUM_W;
    localparam int Q_W   = wmsm_pkg::Q_W;
    localparam logic [SUM_W-1:0] HALF_LSB = SUM_W'(1) << (wmsm_pkg::FRAC_BITS - 1);

    logic signed [SUM_W-1:0]              sum_reg;
    logic signed [SUM_W-1:0]              sum_next;
    logic [SUM_W-1:0]                     mag_round;
    logic [Q_W-1:0]                       q_reg;
    logic                                 neg_reg;
    logic [Q_W-1:0]                       lim_pos;
    logic [Q_W-1:0]                       lim_neg;
    logic signed [wmsm_pkg::SAMPLE_W-1:0] mixed_reg;
    logic signed [wmsm_pkg::SAMPLE_W-1:0] mixed_next;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < wmsm_pkg::LANES; i++)
            sum_next = sum_next + SUM_W'($signed(products[i]));
    end

    // Magnitude plus one half in a single add: -x + h equals ~x + h + 1.
    always_comb
    begin
        if (sum_reg[SUM_W-1])
            mag_round = ~sum_reg + HALF_LSB + SUM_W'(1);
        else
            mag_round = sum_reg + HALF_LSB;
    end

    always_comb
    begin
        unique case (sample_format)
            wmsm_pkg::FMT_8BIT:
            begin
                lim_pos = Q_W'(127);
                lim_neg = Q_W'(128);
            end
            wmsm_pkg::FMT_16BIT:
            begin
                lim_pos = Q_W'(32767);
                lim_neg = Q_W'(32768);
            end
            default:
            begin
                lim_pos = Q_W'(8388607);
                lim_neg = Q_W'(8388608);
            end
        endcase
    end

    always_comb
    begin
        if (neg_reg)
        begin
            if (q_reg > lim_neg)
                mixed_next = -wmsm_pkg::SAMPLE_W'(lim_neg);
            else
                mixed_next = -wmsm_pkg::SAMPLE_W'(q_reg);
        end
        else
        begin
            if (q_reg > lim_pos)
                mixed_next = wmsm_pkg::SAMPLE_W'(lim_pos);
            else
                mixed_next = wmsm_pkg::SAMPLE_W'(q_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.sum)
            sum_reg <= sum_next;
        if (en.rnd)
        begin
            q_reg   <= mag_round[SUM_W-1:wmsm_pkg::FRAC_BITS];
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (en.sat)
            mixed_reg <= mixed_next;
    end

    assign mixed = mixed_reg;

endmodule

[hdl/weighted_multi_stream_mixer.sv]
// ============================================================================
// weighted_multi_stream_mixer: gain-weighted mix of a main and extra streams
// Parallel multiplier lanes feed a merging stage that rounds and saturates.
// ============================================================================
// Usage:
// Each transfer on mix_in carries one channel element: its frame index, the
// main sample and one sample of each extra stream. Each transfer on mix_out
// carries the mixed sample for that element, in order, one for one.
// Gains, stream lengths and the sample format are written through the APB
// port while the block is idle; pready is always high, reads return values.
// Five register stages (sample load, multiply, sum, round, saturate) lie
// between the input transfer and the result on mix_out. One item is taken
// every cycle unless the pipeline is full and stalled: the active stream
// count is updated in the cycle of the transfer. Reset restores the default
// registers, marks the first EXTRA_STREAMS (at most NUM_EXTRA) extra streams
// active and empties the pipeline. When the receiver stalls, the stages hold
// their items and mix_in.ready drops only once every stage is full.
// ============================================================================
module weighted_multi_stream_mixer #(
    parameter int EXTRA_STREAMS = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    wmsm_in_if.sink                       mix_in,
    wmsm_out_if.source                    mix_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wmsm_pkg::ADDR_W-1:0]   paddr,
    input  logic [wmsm_pkg::DATA_W-1:0]   pwdata,
    output logic [wmsm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int NUM_EXTRA = wmsm_pkg::NUM_EXTRA;
    localparam int CNT_W     = wmsm_pkg::CNT_W;
    localparam int STAGES    = 5;

    // Only the streams that have registers can be active after reset.
    localparam logic [CNT_W-1:0] ACTIVE_RESET =
        CNT_W'((EXTRA_STREAMS > NUM_EXTRA) ? NUM_EXTRA : EXTRA_STREAMS);

    wmsm_pkg::wmsm_cfg_t     cfg;
    wmsm_pkg::wmsm_pipe_en_t pipe_en;

    logic [CNT_W-1:0]                                      active_reg;
    logic [CNT_W-1:0]                                      active_next;
    logic [STAGES-1:0]                                     valid_reg;
    logic [STAGES-1:0]                                     valid_next;
    logic [STAGES-1:0]                                     stage_en;
    logic                                                  in_xfer;
    logic [NUM_EXTRA-1:0][wmsm_pkg::SAMPLE_W-1:0]          extra_raw;
    logic [wmsm_pkg::LANES-1:0][wmsm_pkg::PROD_W-1:0]      products;
    logic                                                  offset_mode;

    assign pready = 1'b1;

    wmsm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage loads when it is empty or when the
    // stage after it moves on, so bubbles are squeezed out and the last
    // stage doubles as the output register.
    // ------------------------------------------------------------------
    always_comb
    begin
        stage_en[STAGES-1] = !valid_reg[STAGES-1] || mix_out.ready;
        for (int k = STAGES - 2; k >= 0; k--)
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
    end

    assign mix_in.ready = stage_en[0];
    assign in_xfer      = mix_in.valid && stage_en[0];

    always_comb
    begin
        valid_next[0] = stage_en[0] ? mix_in.valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
            valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
    end

    assign pipe_en.load = stage_en[0];
    assign pipe_en.mult = stage_en[1];
    assign pipe_en.sum  = stage_en[2];
    assign pipe_en.rnd  = stage_en[3];
    assign pipe_en.sat  = stage_en[4];

    // ------------------------------------------------------------------
    // Active stream count. The streams run from longest to shortest, so
    // when the frame index reaches the length of the last active stream,
    // that stream and any trailing streams of the same length drop out
    // for good. A frame index that jumps past a length drops nothing.
    // ------------------------------------------------------------------
    always_comb
    begin
        active_next = active_reg;
        for (int j = NUM_EXTRA; j >= 1; j--)
        begin
            if (active_next == CNT_W'(j) && cfg.extra_len[j-1] == mix_in.frame_index)
                active_next = CNT_W'(j - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
            valid_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (in_xfer)
                active_reg <= active_next;
        end
    end

    // ------------------------------------------------------------------
    // Lanes: lane 0 carries the main stream, which is always signed and
    // always active; the extra lanes follow the updated stream count.
    // ------------------------------------------------------------------
    assign extra_raw[0] = mix_in.extra_sample_a;
    assign extra_raw[1] = mix_in.extra_sample_b;
    assign extra_raw[2] = mix_in.extra_sample_c;
    assign offset_mode  = (cfg.sample_format == wmsm_pkg::FMT_8BIT);

    wmsm_lane u_main_lane (
        .clk         (clk),
        .en          (pipe_en),
        .offset_mode (1'b0),
        .lane_on     (1'b1),
        .raw_sample  (mix_in.main_sample),
        .gain        ($signed(cfg.main_gain)),
        .product     (products[0])
    );

    for (genvar i = 0; i < NUM_EXTRA; i++)
    begin : g_extra_lane
        wmsm_lane u_lane (
            .clk         (clk),
            .en          (pipe_en),
            .offset_mode (offset_mode),
            .lane_on     (active_next > CNT_W'(i)),
            .raw_sample  (extra_raw[i]),
            .gain        ($signed(cfg.extra_gain[i])),
            .product     (products[i+1])
        );
    end

    wmsm_merge u_merge (
        .clk           (clk),
        .en            (pipe_en),
        .sample_format (cfg.sample_format),
        .products      (products),
        .mixed         (mix_out.mixed_sample)
    );

    assign mix_out.valid = valid_reg[STAGES-1];

`ifndef SYNTHESIS
    // Streams only ever drop out; nothing brings one back short of reset.
    a_count_never_rises: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> active_reg <= $past(active_reg))
        else $error("active stream count increased");

    // The stream count moves only with an input transfer.
    a_count_only_on_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        !(mix_in.valid && mix_in.ready) |=> $stable(active_reg))
        else $error("active stream count changed without a transfer");

    // An accepted item always lands in the first stage.
    a_xfer_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (mix_in.valid && mix_in.ready) |=> valid_reg[0])
        else $error("accepted item lost at the first stage");

    // A full pipeline behind a stalled receiver takes no new item.
    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && !mix_out.ready) |-> !mix_in.ready)
        else $error("input accepted while the pipeline is full and stalled");
`endif

endmodule
